>>> sv/alternating_raw_run_pixel_decoder_core_assert.svh
// Assertion macros for the checker file of the decoder.
`ifndef ALTERNATING_RAW_RUN_PIXEL_DECODER_CORE_ASSERT_SVH
`define ALTERNATING_RAW_RUN_PIXEL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define ARRPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define ARRPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/arrpd_pkg.sv
package arrpd_pkg;

  // Input beat: one compressed byte and the picture restart flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       picture_start;
  } in_t;

  // Result beat: pixel value, its repeat count and the end-of-picture flag
  typedef struct packed {
    logic [15:0] pixel;
    logic [16:0] repeat_res;
    logic        last;
  } out_t;

  // Count byte value that announces a following 16-bit extension word
  localparam logic [7:0]  COUNT_EXTEND = 8'd255;
  // Largest count a chunk can carry: 255 plus a full 16-bit word
  localparam logic [16:0] REP_MAX      = 17'd65790;

  // Configuration register indexes
  localparam logic [7:0]  CFG_CHUNK_TOTAL = 8'd0;
  localparam logic [7:0]  CFG_PIXEL_TOTAL = 8'd1;

endpackage

>>> sv/alternating_raw_run_pixel_decoder_core.sv
// Alternating raw/run decoder for 16-bit pixels. It takes one compressed byte
// per beat, one byte every clock cycle unless the result side stalls; each byte
// passes an input register and then the combinational state update into the
// result register. Raw pixels come out with repeat 1, a run chunk as one beat
// with its repeat count (clamped to the pixels still missing; dropped if zero
// and not final), and the final beat of a picture carries last. Bytes after the
// end are dropped until a beat with picture_start arrives. The user writes
// chunk_total (index 0) and pixel_total (index 1) through the cfg port only while
// the block is idle; the block does not enforce this. Both reset to 1.
module alternating_raw_run_pixel_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arrpd_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output arrpd_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam logic [3:0] PH_RAW_CNT    = 4'd0;
  localparam logic [3:0] PH_RAW_EXT_HI = 4'd1;
  localparam logic [3:0] PH_RAW_EXT_LO = 4'd2;
  localparam logic [3:0] PH_PIX_HI     = 4'd3;
  localparam logic [3:0] PH_PIX_LO     = 4'd4;
  localparam logic [3:0] PH_RUN_CNT    = 4'd5;
  localparam logic [3:0] PH_RUN_EXT_HI = 4'd6;
  localparam logic [3:0] PH_RUN_EXT_LO = 4'd7;
  localparam logic [3:0] PH_DONE       = 4'd8;

  logic [31:0]     chunk_total_r;
  logic [31:0]     pixel_total_r;

  logic            s1_valid_r;
  arrpd_pkg::in_t  s1_data_r;
  logic            s1_adv;

  logic [3:0]      phase_r,    phase_nxt;
  logic [16:0]     rem_r,      rem_nxt;
  logic [31:0]     chunks_r,   chunks_nxt;
  logic [31:0]     written_r,  written_nxt;
  logic [15:0]     prev_r,     prev_nxt;
  logic [7:0]      held_r,     held_nxt;

  logic            out_valid_r;
  arrpd_pkg::out_t out_data_r;
  logic            emit;
  arrpd_pkg::out_t res;

  logic [3:0]      cur_phase;
  logic [16:0]     cur_rem;
  logic [31:0]     cur_chunks;
  logic [31:0]     cur_written;
  logic [15:0]     cur_prev;
  logic [7:0]      cur_held;

  logic [7:0]      b;
  logic [15:0]     word;
  logic [16:0]     cnt;
  logic [31:0]     chunks_dec;
  logic            budget_last;
  logic            pw_ge;
  logic [31:0]     diff;
  logic            cnt_ge_diff;
  logic [16:0]     rep;
  logic            run_last;
  logic [16:0]     rem_dec;
  logic            pix_last;

  // Handshakes: the input register moves on whenever the result register frees
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_total_r <= 32'd1;
      pixel_total_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arrpd_pkg::CFG_CHUNK_TOTAL: chunk_total_r <= cfg_data;
        arrpd_pkg::CFG_PIXEL_TOTAL: pixel_total_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold the accepted beat until the update takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Restart the picture state ahead of the update when picture_start is set
  always_comb begin
    if (s1_data_r.picture_start) begin
      cur_phase   = PH_RAW_CNT;
      cur_rem     = '0;
      cur_chunks  = chunk_total_r;
      cur_written = '0;
      cur_prev    = '0;
      cur_held    = '0;
    end else begin
      cur_phase   = phase_r;
      cur_rem     = rem_r;
      cur_chunks  = chunks_r;
      cur_written = written_r;
      cur_prev    = prev_r;
      cur_held    = held_r;
    end
  end

  // Shared arithmetic for counts, budget and pixel clamping
  always_comb begin
    b           = s1_data_r.data_byte;
    word        = {cur_held, b};
    if (cur_phase == PH_RAW_EXT_LO || cur_phase == PH_RUN_EXT_LO) begin
      cnt = 17'(word) + 17'(arrpd_pkg::COUNT_EXTEND);
    end else begin
      cnt = 17'(b);
    end
    chunks_dec  = cur_chunks - 32'd1;
    budget_last = (cur_chunks == 32'd1);
    pw_ge       = (cur_written >= pixel_total_r);
    diff        = pixel_total_r - cur_written;
    cnt_ge_diff = (32'(cnt) >= diff);
    if (pw_ge) begin
      rep = '0;
    end else if (cnt_ge_diff) begin
      rep = diff[16:0];
    end else begin
      rep = cnt;
    end
    run_last    = budget_last || pw_ge || cnt_ge_diff;
    rem_dec     = cur_rem - 17'd1;
    pix_last    = ((rem_dec == '0) && budget_last) || (diff == 32'd1);
  end

  // Per-byte state update
  always_comb begin
    phase_nxt   = cur_phase;
    rem_nxt     = cur_rem;
    chunks_nxt  = cur_chunks;
    written_nxt = cur_written;
    prev_nxt    = cur_prev;
    held_nxt    = cur_held;
    emit        = 1'b0;
    res         = '0;
    case (cur_phase)
      PH_RAW_CNT, PH_RAW_EXT_LO: begin
        if (cur_phase == PH_RAW_CNT && b == arrpd_pkg::COUNT_EXTEND) begin
          phase_nxt = PH_RAW_EXT_HI;
        end else if (cnt == '0) begin
          // empty raw chunk: close it, mark the end if the budget is spent
          chunks_nxt = chunks_dec;
          if (budget_last) begin
            emit      = 1'b1;
            res.last  = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_RUN_CNT;
          end
        end else begin
          rem_nxt   = cnt;
          phase_nxt = PH_PIX_HI;
        end
      end
      PH_RAW_EXT_HI, PH_RUN_EXT_HI, PH_PIX_HI: begin
        held_nxt  = b;
        phase_nxt = cur_phase + 4'd1;
      end
      PH_PIX_LO: begin
        emit = 1'b1;
        if (pw_ge) begin
          res.last  = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          prev_nxt       = word;
          written_nxt    = cur_written + 32'd1;
          rem_nxt        = rem_dec;
          if (rem_dec == '0) begin
            chunks_nxt = chunks_dec;
          end
          res.pixel      = word;
          res.repeat_res = 17'd1;
          res.last       = pix_last;
          if (pix_last) begin
            phase_nxt = PH_DONE;
          end else if (rem_dec == '0) begin
            phase_nxt = PH_RUN_CNT;
          end else begin
            phase_nxt = PH_PIX_HI;
          end
        end
      end
      PH_RUN_CNT, PH_RUN_EXT_LO: begin
        if (cur_phase == PH_RUN_CNT && b == arrpd_pkg::COUNT_EXTEND) begin
          phase_nxt = PH_RUN_EXT_HI;
        end else begin
          chunks_nxt  = chunks_dec;
          written_nxt = cur_written + 32'(rep);
          phase_nxt   = run_last ? PH_DONE : PH_RAW_CNT;
          // drop a clamped-away run unless it closes the picture
          if (rep != '0 || run_last) begin
            emit           = 1'b1;
            res.pixel      = (rep != '0) ? cur_prev : 16'd0;
            res.repeat_res = rep;
            res.last       = run_last;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RAW_CNT;
      rem_r     <= '0;
      chunks_r  <= '0;
      written_r <= '0;
      prev_r    <= '0;
      held_r    <= '0;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      chunks_r  <= chunks_nxt;
      written_r <= written_nxt;
      prev_r    <= prev_nxt;
      held_r    <= held_nxt;
    end
  end

  // Result register: load on update, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data_r <= res;
    end
  end

endmodule

>>> sv/arrpd_checker.sv
`include "alternating_raw_run_pixel_decoder_core_assert.svh"

module arrpd_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            out_valid,
  input  logic            out_ready,
  input  arrpd_pkg::out_t out_data
);

  // A stalled result beat stays offered
  `ARRPD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // A zero repeat is only ever the empty final marker
  `ARRPD_ASSERT_IMP(a_marker, out_valid && out_data.repeat_res == 17'd0, out_data.last && out_data.pixel == 16'd0, "zero repeat without empty final marker")

  // Repeat never exceeds the largest chunk count
  `ARRPD_ASSERT_IMP(a_rep_max, out_valid, out_data.repeat_res <= arrpd_pkg::REP_MAX, "repeat beyond largest chunk count")

  // No result straight out of reset
  `ARRPD_ASSERT_IMP(a_rst_quiet, $past(!rst_n), !out_valid, "result offered right after reset")

endmodule

bind alternating_raw_run_pixel_decoder_core arrpd_checker u_arrpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  // Decoder position within the chunk stream
  localparam logic [3:0] ST_RAW_COUNT  = 4'd0;
  localparam logic [3:0] ST_RAW_EXT_HI = 4'd1;
  localparam logic [3:0] ST_RAW_EXT_LO = 4'd2;
  localparam logic [3:0] ST_PIX_HI     = 4'd3;
  localparam logic [3:0] ST_PIX_LO     = 4'd4;
  localparam logic [3:0] ST_RUN_COUNT  = 4'd5;
  localparam logic [3:0] ST_RUN_EXT_HI = 4'd6;
  localparam logic [3:0] ST_RUN_EXT_LO = 4'd7;
  localparam logic [3:0] ST_DONE       = 4'd8;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  arrpd_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready = 1'b0;
  arrpd_pkg::out_t out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [7:0]      cfg_index;
  logic [31:0]     cfg_data;

  // Predicted decoder state and register copies
  logic [31:0] m_chunk_total;
  logic [31:0] m_pixel_total;
  logic [3:0]  m_state;
  logic [16:0] m_left_in_chunk;
  logic [31:0] m_chunks_left;
  logic [31:0] m_written;
  logic [15:0] m_last_pixel;
  logic [7:0]  m_high_byte;

  arrpd_pkg::out_t expected_beats[$];
  arrpd_pkg::out_t want_beat;

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;
  int bytes_sent    = 0;
  int pic_budget    = 0;
  bit pic_first     = 1'b0;

  alternating_raw_run_pixel_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Pixel prediction
  // ---------------------------------------------------------------------------

  function automatic bit spend_chunk();
    m_chunks_left = m_chunks_left - 32'd1;
    return m_chunks_left == 32'd0;
  endfunction

  function automatic logic [16:0] extended_count(input logic [7:0] lo);
    return {9'd0, arrpd_pkg::COUNT_EXTEND} + {1'b0, m_high_byte, lo};
  endfunction

  task automatic queue_pixel(input logic [15:0] px, input logic [16:0] rep,
                             input logic lst);
    arrpd_pkg::out_t r;
    r.pixel      = px;
    r.repeat_res = rep;
    r.last       = lst;
    expected_beats.push_back(r);
    if (lst) m_state = ST_DONE;
  endtask

  task automatic open_raw_chunk(input logic [16:0] count);
    if (count == 17'd0) begin
      if (spend_chunk()) queue_pixel(16'd0, 17'd0, 1'b1);
      else m_state = ST_RUN_COUNT;
    end else begin
      m_left_in_chunk = count;
      m_state         = ST_PIX_HI;
    end
  endtask

  // Clamp the run to the pixels still missing; drop it when empty and not final
  task automatic close_run_chunk(input logic [16:0] count);
    logic [31:0] missing;
    logic [31:0] reps;
    bit          spent;
    bit          lst;
    missing   = (m_pixel_total > m_written) ? m_pixel_total - m_written : 32'd0;
    reps      = ({15'd0, count} < missing) ? {15'd0, count} : missing;
    spent     = spend_chunk();
    m_written = m_written + reps;
    lst       = spent || (m_written >= m_pixel_total);
    m_state   = ST_RAW_COUNT;
    if (reps != 32'd0 || lst)
      queue_pixel((reps != 32'd0) ? m_last_pixel : 16'd0, reps[16:0], lst);
  endtask

  task automatic take_pixel(input logic [15:0] px);
    bit spent;
    spent = 1'b0;
    if (m_written >= m_pixel_total) begin
      queue_pixel(16'd0, 17'd0, 1'b1);
    end else begin
      m_last_pixel    = px;
      m_written       = m_written + 32'd1;
      m_left_in_chunk = m_left_in_chunk - 17'd1;
      if (m_left_in_chunk == 17'd0) spent = spend_chunk();
      m_state = (m_left_in_chunk == 17'd0) ? ST_RUN_COUNT : ST_PIX_HI;
      queue_pixel(px, 17'd1, spent || (m_written >= m_pixel_total));
    end
  endtask

  task automatic decode_byte(input arrpd_pkg::in_t beat);
    logic [7:0] b;
    b = beat.data_byte;
    // Restart the picture from the chunk budget
    if (beat.picture_start) begin
      m_state         = ST_RAW_COUNT;
      m_left_in_chunk = '0;
      m_chunks_left   = m_chunk_total;
      m_written       = '0;
      m_last_pixel    = '0;
      m_high_byte     = '0;
    end
    case (m_state)
      ST_RAW_COUNT: begin
        if (b == arrpd_pkg::COUNT_EXTEND) m_state = ST_RAW_EXT_HI;
        else open_raw_chunk({9'd0, b});
      end
      ST_RAW_EXT_HI: begin
        m_high_byte = b;
        m_state     = ST_RAW_EXT_LO;
      end
      ST_RAW_EXT_LO: open_raw_chunk(extended_count(b));
      ST_PIX_HI: begin
        m_high_byte = b;
        m_state     = ST_PIX_LO;
      end
      ST_PIX_LO: take_pixel({m_high_byte, b});
      ST_RUN_COUNT: begin
        if (b == arrpd_pkg::COUNT_EXTEND) m_state = ST_RUN_EXT_HI;
        else close_run_chunk({9'd0, b});
      end
      ST_RUN_EXT_HI: begin
        m_high_byte = b;
        m_state     = ST_RUN_EXT_LO;
      end
      ST_RUN_EXT_LO: close_run_chunk(extended_count(b));
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on each input beat, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == arrpd_pkg::CFG_CHUNK_TOTAL) m_chunk_total = cfg_data;
        else if (cfg_index == arrpd_pkg::CFG_PIXEL_TOTAL) m_pixel_total = cfg_data;
      end
      if (in_valid && in_ready) decode_byte(in_data);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: pixel %h repeat_res %0d last %0b",
                 out_data.pixel, out_data.repeat_res, out_data.last);
          errors++;
        end else begin
          want_beat = expected_beats.pop_front();
          if (out_data.pixel !== want_beat.pixel) begin
            $error("pixel: expected %h, actual %h", want_beat.pixel, out_data.pixel);
            errors++;
          end
          if (out_data.repeat_res !== want_beat.repeat_res) begin
            $error("repeat_res: expected %0d, actual %0d",
                   want_beat.repeat_res, out_data.repeat_res);
            errors++;
          end
          if (out_data.last !== want_beat.last) begin
            $error("last: expected %0b, actual %0b", want_beat.last, out_data.last);
            errors++;
          end
        end
      end
    end
  end

  // Result side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when no channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("** alternating_raw_run_pixel_decoder_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte, with a random gap first, and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic start);
    arrpd_pkg::in_t beat;
    beat.data_byte     = b;
    beat.picture_start = start;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every predicted result has arrived and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] chunks, input logic [31:0] pixels);
    cfg_valid <= 1'b1;
    cfg_index <= arrpd_pkg::CFG_CHUNK_TOTAL;
    cfg_data  <= chunks;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= arrpd_pkg::CFG_PIXEL_TOTAL;
    cfg_data  <= pixels;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Send one picture byte unless the picture has been cut short
  task automatic feed_byte(input logic [7:0] b);
    if (pic_budget > 0) begin
      push_byte(b, pic_first);
      pic_first  = 1'b0;
      pic_budget = pic_budget - 1;
      bytes_sent = bytes_sent + 1;
    end
  endtask

  // Build one well-formed picture (sometimes truncated) with random content
  task automatic send_picture(input logic [31:0] chunks, input logic [31:0] pixels);
    longint     lim;
    longint     gen_px;
    int         nch;
    int         ci;
    int         cnt;
    int         r;
    int         i;
    logic [7:0] hi;
    logic [7:0] lo;
    lim        = (pixels == 0) ? 1 : ((pixels > 600) ? 600 : pixels);
    nch        = (chunks == 0 || chunks > 16) ? 16 : int'(chunks);
    gen_px     = 0;
    ci         = 0;
    pic_first  = 1'b1;
    pic_budget = ($urandom_range(99) < 10) ? $urandom_range(1, 10) : 1 << 30;
    while (ci < nch && gen_px < lim) begin
      // raw chunk: count, optional extension, then big-endian pixels
      r = $urandom_range(99);
      if (r < 5) begin
        lo  = 8'($urandom_range(255));
        cnt = 255 + lo;
        feed_byte(arrpd_pkg::COUNT_EXTEND);
        feed_byte(8'd0);
        feed_byte(lo);
      end else begin
        cnt = (r < 15) ? $urandom_range(7, 254) : $urandom_range(0, 6);
        feed_byte(8'(cnt));
      end
      for (i = 0; i < cnt && gen_px < lim; i++) begin
        feed_byte(8'($urandom_range(255)));
        feed_byte(8'($urandom_range(255)));
        gen_px++;
      end
      ci++;
      if (ci >= nch || gen_px >= lim) break;
      // run chunk: count only
      r = $urandom_range(99);
      if (r < 15) begin
        hi  = 8'($urandom_range(255));
        lo  = 8'($urandom_range(255));
        cnt = 255 + {hi, lo};
        feed_byte(arrpd_pkg::COUNT_EXTEND);
        feed_byte(hi);
        feed_byte(lo);
      end else begin
        cnt = (r < 40) ? $urandom_range(0, 254) : $urandom_range(0, 10);
        feed_byte(8'(cnt));
      end
      gen_px += cnt;
      ci++;
    end
    // trailing noise, dropped once the picture has ended
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, no restart: budget wraps, one pixel ends it, then a dropped byte
  task automatic test_reset_defaults();
    push_byte(8'h01, 1'b0);
    push_byte(8'hAB, 1'b0);
    push_byte(8'hCD, 1'b0);
    push_byte(8'h07, 1'b0);
    settle();
  endtask

  // Budget spent on an empty raw chunk gives an empty final marker
  task automatic test_empty_final_chunk();
    set_config(32'd1, 32'd1);
    push_byte(8'h00, 1'b1);
    settle();
  endtask

  // Zero budget, longest run before any pixel, extreme pixels, extended run
  task automatic test_wrapped_budget_and_extensions();
    set_config(32'd0, 32'hFFFF_FFFF);
    push_byte(8'h00, 1'b1);
    push_byte(arrpd_pkg::COUNT_EXTEND, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(arrpd_pkg::COUNT_EXTEND, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    settle();
  endtask

  // Nothing missing: zero pixel total, then a total lowered below what is written
  task automatic test_no_pixels_missing();
    set_config(32'd3, 32'd0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    settle();
    set_config(32'd5, 32'd100);
    push_byte(8'h02, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    settle();
    set_config(32'd5, 32'd1);
    push_byte(8'h03, 1'b0);
    settle();
  endtask

  // Hold the result side for a long stretch while a raw chunk keeps coming
  task automatic test_backpressure();
    settle();
    set_config(32'd0, 32'hFFFF_FFFF);
    hold_requests = hold_requests + 1;
    push_byte(8'd40, 1'b1);
    repeat (80) push_byte(8'($urandom_range(255)), 1'b0);
    push_byte(8'd3, 1'b0);
    settle();
  endtask

  task automatic test_random_pictures(input int target);
    int          start;
    int          sel;
    logic [31:0] chunks;
    logic [31:0] pixels;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      settle();
      sel    = $urandom_range(19);
      chunks = (sel == 0) ? 32'd0 :
               (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 12));
      sel    = $urandom_range(19);
      pixels = (sel == 0) ? 32'd0 :
               (sel == 1) ? 32'hFFFF_FFFF :
               (sel == 2) ? 32'hFFFE_0001 : 32'($urandom_range(1, 48));
      set_config(chunks, pixels);
      repeat ($urandom_range(1, 3)) send_picture(chunks, pixels);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    // Predicted state after reset
    m_chunk_total   = 32'd1;
    m_pixel_total   = 32'd1;
    m_state         = ST_RAW_COUNT;
    m_left_in_chunk = '0;
    m_chunks_left   = '0;
    m_written       = '0;
    m_last_pixel    = '0;
    m_high_byte     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 69;
    test_reset_defaults();
    test_empty_final_chunk();
    test_wrapped_budget_and_extensions();
    test_no_pixels_missing();
    test_random_pictures(560);

    send_idle_pct = 69;
    recv_idle_pct = 22;
    test_random_pictures(560);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_pictures(480);
    test_backpressure();

    settle();
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("** alternating_raw_run_pixel_decoder_core: PASSED **");
    end else begin
      $display("** alternating_raw_run_pixel_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/arrpd_pkg.sv
sv/alternating_raw_run_pixel_decoder_core.sv
sv/arrpd_checker.sv
tb/testbench.sv
